@@ rtl/acpu_pkg.sv @@
// Shared opcodes, sizes and execute-unit interface types for the accumulator CPU.
package acpu_pkg;

	// Default data memory depth in bytes
	localparam int unsigned MEM_DEPTH_DEF = 256;

	// Steps of an iterative multiply or divide, one bit per step
	localparam int unsigned ALU_STEPS = 8;

	// Instruction opcodes
	localparam logic [7:0] OP_LOADM = 8'd0;
	localparam logic [7:0] OP_LOADV = 8'd1;
	localparam logic [7:0] OP_STORE = 8'd2;
	localparam logic [7:0] OP_ADD   = 8'd3;
	localparam logic [7:0] OP_SUB   = 8'd4;
	localparam logic [7:0] OP_MUL   = 8'd5;
	localparam logic [7:0] OP_DIV   = 8'd6;
	localparam logic [7:0] OP_INC   = 8'd7;
	localparam logic [7:0] OP_DEC   = 8'd8;
	localparam logic [7:0] OP_AND   = 8'd9;
	localparam logic [7:0] OP_OR    = 8'd10;
	localparam logic [7:0] OP_NOT   = 8'd11;
	localparam logic [7:0] OP_JMP   = 8'd12;
	localparam logic [7:0] OP_JZ    = 8'd13;
	localparam logic [7:0] OP_JNZ   = 8'd14;
	localparam logic [7:0] OP_JG    = 8'd15;
	localparam logic [7:0] OP_JL    = 8'd16;
	localparam logic [7:0] OP_JGE   = 8'd17;
	localparam logic [7:0] OP_JLE   = 8'd18;
	localparam logic [7:0] OP_HALT  = 8'd19;

	// Request from the sequencer to the execute unit
	typedef struct packed {
		logic       start;
		logic [7:0] op;
		logic [7:0] a;
		logic [7:0] m;
		logic [7:0] opd;
	} alu_req_t;

	// Status back from the execute unit
	typedef struct packed {
		logic       done;
		logic [7:0] result;
	} alu_sts_t;

endpackage

@@ rtl/accumulator_cpu_execute.sv @@
// Top level of the accumulator CPU execute stage: sequencer, state and data memory.
//
// Each request is one instruction (op_code, operand_byte) fetched by the user at next_pc;
// the block answers with one result holding the accumulator, the next fetch address and
// the halt flag. One instruction is in flight at a time: in_ready is high only while the
// sequencer is idle. A request passes through memory read, execute, commit and output
// hand-off; mul and div stay longer in execute while the shared adder runs one bit per
// cycle; once halted a request goes straight to output hand-off. The result
// register frees the input side, but the next request waits until the previous result
// is taken if it reaches hand-off first. The data memory reads as zero after reset
// through per-byte valid flags, so no clearing pass is needed; operand addresses wrap
// modulo MEM_DEPTH.
module accumulator_cpu_execute import acpu_pkg::*; #(
	parameter int unsigned MEM_DEPTH = MEM_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] op_code,
	input  logic [7:0] operand_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] acc_value,
	output logic [7:0] next_pc,
	output logic       halted
);

	localparam int unsigned AW = $clog2(MEM_DEPTH);
	localparam logic [11:0] DEPTH_W = 12'(MEM_DEPTH);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_EXEC = 3'd2;
	localparam logic [2:0] S_WAIT = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]           state_q;
	logic [7:0]           acc_q;
	logic [7:0]           pc_q;
	logic                 halt_q;
	logic [MEM_DEPTH-1:0] vld_q;
	logic                 mval_q;
	logic [7:0]           op_q;
	logic [7:0]           opd_q;
	logic [AW-1:0]        addr_q;
	logic                 out_valid_q;
	logic [7:0]           out_acc_q;
	logic [7:0]           out_pc_q;
	logic                 out_halt_q;

	logic          accept;
	logic          out_free;
	logic [AW-1:0] in_addr;
	logic [7:0]    ram_rdata;
	logic          ram_we;
	logic [7:0]    mem_byte;
	logic          jump;
	alu_req_t      alu_req;
	alu_sts_t      alu_sts;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Wrap the operand into the memory: four compare-subtract steps
	always_comb begin
		logic [11:0] r;
		r = {4'b0, operand_byte};
		for (int k = 3; k >= 0; k--) begin
			if (r >= (DEPTH_W << k)) begin
				r = r - (DEPTH_W << k);
			end
		end
		in_addr = r[AW-1:0];
	end

	// Data memory
	assign ram_we = (state_q == S_EXEC) && (op_q == OP_STORE);

	acpu_ram #(
		.WIDTH(8),
		.DEPTH(MEM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_q),
		.wdata(acc_q),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

	// Bytes never written read as zero
	assign mem_byte = mval_q ? ram_rdata : 8'd0;

	// Execute unit request
	assign alu_req.start = (state_q == S_EXEC);
	assign alu_req.op    = op_q;
	assign alu_req.a     = acc_q;
	assign alu_req.m     = mem_byte;
	assign alu_req.opd   = opd_q;

	acpu_alu u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (alu_req),
		.sts   (alu_sts)
	);

	// Decide the branch from the accumulator before the instruction
	always_comb begin
		case (op_q)
			OP_JMP:  jump = 1'b1;
			OP_JZ:   jump = (acc_q == 8'd0);
			OP_JNZ:  jump = (acc_q != 8'd0);
			OP_JG:   jump = !acc_q[7] && (acc_q != 8'd0);
			OP_JL:   jump = acc_q[7];
			OP_JGE:  jump = !acc_q[7];
			OP_JLE:  jump = acc_q[7] || (acc_q == 8'd0);
			default: jump = 1'b0;
		endcase
	end

	// Sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			acc_q       <= '0;
			pc_q        <= '0;
			halt_q      <= 1'b0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= halt_q ? S_DONE : S_RD;
					end
				end
				S_RD: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (ram_we) begin
						vld_q[addr_q] <= 1'b1;
					end
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (alu_sts.done) begin
						acc_q <= alu_sts.result;
						if (op_q == OP_HALT) begin
							halt_q <= 1'b1;
						end else if (jump) begin
							pc_q <= opd_q;
						end else begin
							pc_q <= pc_q + 8'd1;
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// Hold the result until taken
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Latch the request, memory valid flag and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_code;
			opd_q  <= operand_byte;
			addr_q <= in_addr;
		end
		if (state_q == S_RD) begin
			mval_q <= vld_q[addr_q];
		end
		if (state_q == S_DONE && out_free) begin
			out_acc_q  <= acc_q;
			out_pc_q   <= pc_q;
			out_halt_q <= halt_q;
		end
	end

	assign out_valid = out_valid_q;
	assign acc_value = out_acc_q;
	assign next_pc   = out_pc_q;
	assign halted    = out_halt_q;

`ifndef SYNTH
	// An accepted request always leaves the idle state
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("sequencer stayed idle after a request");

	// Halt is sticky
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt flag cleared");

	// Execute unit completes only while the sequencer waits for it
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		alu_sts.done |-> state_q == S_WAIT)
		else $error("execute unit finished outside the wait state");

	// A halted machine never touches the data memory
	a_halt_no_store: assert property (@(posedge clk) disable iff (!arst_n)
		$past(halt_q) && halt_q |-> !ram_we)
		else $error("store while halted");
`endif

endmodule

@@ rtl/acpu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module acpu_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/acpu_alu.sv @@
// Shared execute unit: one adder serving simple ops and bit-serial multiply and divide.
module acpu_alu import acpu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t req,
	output alu_sts_t sts
);

	logic       busy_q;
	logic       mul_q;
	logic [3:0] cnt_q;
	logic       done_q;
	logic [7:0] acc_q;
	logic [7:0] x_q;
	logic [7:0] y_q;
	logic [7:0] res_q;

	logic [8:0] ax;
	logic [8:0] ay;
	logic       sub;
	logic [9:0] sum;
	logic [7:0] mul_acc;
	logic       div_ok;
	logic [7:0] div_rem;
	logic [7:0] div_quo;
	logic [7:0] simple_res;

	// Select adder operands: iteration steps first, else the requested op
	always_comb begin
		ax  = {1'b0, req.a};
		ay  = {1'b0, req.m};
		sub = 1'b0;
		if (busy_q && mul_q) begin
			ax = {1'b0, acc_q};
			ay = {1'b0, x_q};
		end else if (busy_q) begin
			ax  = {acc_q, x_q[7]};
			ay  = {1'b0, y_q};
			sub = 1'b1;
		end else begin
			case (req.op)
				OP_SUB: sub = 1'b1;
				OP_INC: ay = 9'd1;
				OP_DEC: begin
					ay  = 9'd1;
					sub = 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Shared adder; bit 9 is the carry out, high when no borrow on subtract
	assign sum = {1'b0, ax} + {1'b0, ay ^ {9{sub}}} + 10'(sub);

	// Shift-and-add multiply step
	assign mul_acc = y_q[0] ? sum[7:0] : acc_q;

	// Restoring divide step
	assign div_ok  = sum[9];
	assign div_rem = div_ok ? sum[7:0] : ax[7:0];
	assign div_quo = {x_q[6:0], div_ok};

	// Single-step results
	always_comb begin
		case (req.op)
			OP_LOADM: simple_res = req.m;
			OP_LOADV: simple_res = req.opd;
			OP_ADD,
			OP_SUB,
			OP_INC,
			OP_DEC:   simple_res = sum[7:0];
			OP_AND:   simple_res = req.a & req.m;
			OP_OR:    simple_res = req.a | req.m;
			OP_NOT:   simple_res = ~req.a;
			default:  simple_res = req.a;
		endcase
	end

	// Sequence the unit: start, count steps, flag completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mul_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (req.start) begin
				if (req.op == OP_MUL || req.op == OP_DIV) begin
					busy_q <= 1'b1;
					mul_q  <= (req.op == OP_MUL);
					cnt_q  <= 4'(ALU_STEPS);
				end else begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Advance the working registers and capture the result
	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (mul_q) begin
				acc_q <= mul_acc;
				x_q   <= {x_q[6:0], 1'b0};
				y_q   <= {1'b0, y_q[7:1]};
			end else begin
				acc_q <= div_rem;
				x_q   <= div_quo;
			end
			if (cnt_q == 4'd1) begin
				res_q <= mul_q ? mul_acc : div_quo;
			end
		end else if (req.start) begin
			acc_q <= '0;
			x_q   <= req.a;
			y_q   <= req.m;
			res_q <= simple_res;
		end
	end

	assign sts.done   = done_q;
	assign sts.result = res_q;

endmodule

@@ bench/accumulator_cpu_execute_check.sv @@
// Checker for the accumulator CPU execute stage: tracks machine state and compares results.
`timescale 1ns / 100ps

module accumulator_cpu_execute_check import acpu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  op_code,
	input  logic [7:0]  operand_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  acc_value,
	input  logic [7:0]  next_pc,
	input  logic        halted,
	output int unsigned fail_count,
	output int unsigned pending,
	output int unsigned results_seen
);

	localparam int unsigned CAW = $clog2(MEM_DEPTH_DEF);

	// Architectural state as seen after one instruction
	typedef struct packed {
		logic [7:0] acc;
		logic [7:0] pc;
		logic       halt;
	} cpu_view_t;

	logic [7:0] acc_q;
	logic [7:0] pc_q;
	logic       halt_q;
	logic [7:0] data_mem [MEM_DEPTH_DEF];
	cpu_view_t  expected_views [$];

	// Print one line per problem and count it
	task automatic note_failure(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	// Run one instruction against the tracked state and queue the view it leaves
	task automatic execute_instruction(input logic [7:0] op, input logic [7:0] opd);
		logic [7:0]     mval;
		logic [7:0]     a;
		logic [7:0]     pc_step;
		logic           jump;
		logic [CAW-1:0] idx;
		if (!halt_q) begin
			idx = CAW'(opd % MEM_DEPTH_DEF);
			mval = data_mem[idx];
			a = acc_q;
			jump = 1'b0;
			pc_step = pc_q + 8'd1;
			case (op)
				OP_LOADM: a = mval;
				OP_LOADV: a = opd;
				OP_STORE: data_mem[idx] = a;
				OP_ADD:   a = a + mval;
				OP_SUB:   a = a - mval;
				OP_MUL:   a = a * mval;
				OP_DIV:   a = (mval == 8'd0) ? 8'hFF : a / mval;
				OP_INC:   a = a + 8'd1;
				OP_DEC:   a = a - 8'd1;
				OP_AND:   a = a & mval;
				OP_OR:    a = a | mval;
				OP_NOT:   a = ~a;
				OP_JMP:   jump = 1'b1;
				OP_JZ:    jump = (a == 8'd0);
				OP_JNZ:   jump = (a != 8'd0);
				// signed tests read bit 7 as the sign
				OP_JG:    jump = !a[7] && (a != 8'd0);
				OP_JL:    jump = a[7];
				OP_JGE:   jump = !a[7];
				OP_JLE:   jump = a[7] || (a == 8'd0);
				OP_HALT: begin
					halt_q = 1'b1;
					pc_step = pc_q;
				end
				default: ;
			endcase
			acc_q = a;
			pc_q = jump ? opd : pc_step;
		end
		expected_views.push_back('{acc: acc_q, pc: pc_q, halt: halt_q});
	endtask

	// Watch both channels; check results before queueing the new request
	always @(posedge clk or negedge arst_n) begin
		cpu_view_t want;
		if (!arst_n) begin
			acc_q = 8'd0;
			pc_q = 8'd0;
			halt_q = 1'b0;
			data_mem = '{default: 8'd0};
			expected_views.delete();
			fail_count = 0;
			results_seen = 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_views.size() == 0) begin
					note_failure($sformatf("result acc=%02h pc=%02h halted=%0b with nothing pending",
						acc_value, next_pc, halted));
				end else begin
					want = expected_views.pop_front();
					if (acc_value !== want.acc)
						note_failure($sformatf("acc_value got %02h expected %02h",
							acc_value, want.acc));
					if (next_pc !== want.pc)
						note_failure($sformatf("next_pc got %02h expected %02h",
							next_pc, want.pc));
					if (halted !== want.halt)
						note_failure($sformatf("halted got %0b expected %0b",
							halted, want.halt));
				end
			end
			if (in_valid && in_ready)
				execute_instruction(op_code, operand_byte);
		end
		pending = expected_views.size();
	end

endmodule

@@ bench/accumulator_cpu_execute_test.sv @@
// Top of the accumulator CPU execute stage bench: clock, reset, requests and verdict.
`timescale 1ns / 100ps

module accumulator_cpu_execute_test import acpu_pkg::*;;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  op_code;
	logic [7:0]  operand_byte;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  acc_value;
	logic [7:0]  next_pc;
	logic        halted;
	logic        steady;
	int unsigned fail_count;
	int unsigned pending;
	int unsigned results_seen;
	int unsigned requests_sent;

	accumulator_cpu_execute uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op_code      (op_code),
		.operand_byte (operand_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.acc_value    (acc_value),
		.next_pc      (next_pc),
		.halted       (halted)
	);

	accumulator_cpu_execute_check u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op_code      (op_code),
		.operand_byte (operand_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.acc_value    (acc_value),
		.next_pc      (next_pc),
		.halted       (halted),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Stall the result side about a fifth of the time, never during the steady window
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= steady || ($urandom_range(0, 99) >= 20);
		end
	end

	// Abort a hung run
	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	// Hand one request to the block, with an optional random gap in front
	task automatic send_request(input logic [7:0] op, input logic [7:0] opd);
		while (!steady && $urandom_range(0, 99) < 20) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op_code <= op;
		operand_byte <= opd;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		requests_sent++;
	endtask

	// Favor stores and loads so memory fills up; leave halt for the end
	function automatic logic [7:0] pick_opcode();
		int unsigned pct;
		pct = $urandom_range(0, 99);
		if (pct < 15)
			return OP_STORE;
		if (pct < 25)
			return OP_LOADV;
		if (pct < 30)
			return OP_LOADM;
		if (pct < 88)
			return 8'($urandom_range(OP_LOADM, OP_JLE));
		return 8'($urandom_range(OP_HALT + 1, 255));
	endfunction

	// Cluster addresses at both ends so stored bytes get read back
	function automatic logic [7:0] pick_operand();
		case ($urandom_range(0, 3))
			2: return 8'($urandom_range(0, 7));
			3: return 8'($urandom_range(248, 255));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		in_valid = 1'b0;
		op_code = 8'd0;
		operand_byte = 8'd0;
		steady = 1'b0;
		requests_sent = 0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: zero and sign boundaries for every jump, divide by zero, extremes
		send_request(OP_LOADV, 8'hFF);
		send_request(OP_STORE, 8'hFF);
		send_request(OP_LOADV, 8'h00);
		send_request(OP_JZ, 8'h10);
		send_request(OP_JNZ, 8'h20);
		send_request(OP_JLE, 8'hAA);
		send_request(OP_JG, 8'h55);
		send_request(OP_DIV, 8'h00);
		send_request(OP_JL, 8'hF0);
		send_request(OP_JGE, 8'h0F);
		send_request(OP_INC, 8'h00);
		send_request(OP_DEC, 8'h00);
		send_request(OP_NOT, 8'h00);
		send_request(OP_LOADM, 8'hFF);
		send_request(OP_ADD, 8'hFF);
		send_request(OP_SUB, 8'hFF);
		send_request(OP_MUL, 8'hFF);
		send_request(OP_LOADV, 8'h7F);
		send_request(OP_JG, 8'h80);
		send_request(OP_AND, 8'hFF);
		send_request(OP_OR, 8'hFF);
		send_request(OP_DIV, 8'hFF);
		send_request(OP_JMP, 8'hFF);
		send_request(OP_HALT + 8'd1, 8'h00);
		send_request(8'hFF, 8'h01);

		// Random instruction stream with a stretch of full throughput in the middle
		for (int i = 0; i < 600; i++) begin
			steady = (i >= 250) && (i < 350);
			send_request(pick_opcode(), pick_operand());
		end
		steady = 1'b0;

		// Halt, then confirm that later instructions leave the state alone
		send_request(OP_HALT, pick_operand());
		send_request(OP_LOADV, 8'h5A);
		send_request(OP_JMP, 8'h33);
		send_request(OP_STORE, 8'h00);
		send_request(8'($urandom_range(OP_HALT + 1, 255)), pick_operand());
		in_valid <= 1'b0;

		// Drain, then watch for stray results
		while (pending != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		$display("Sent %0d instructions (directed, random, halt tail); %0d results compared.",
			requests_sent, results_seen);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
